FILE: sv/cda_pkg.sv
// Shared types, constants and month-length lookup for the date adder.
package cda_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int COUNT_W  = 16;
  localparam int CENT_W   = 8;
  localparam int YY_W     = 7;
  localparam int DIV100_W = 13;
  localparam int PROD_W   = YEAR_W + DIV100_W;
  localparam int DIV100_SHIFT = 19;

  localparam logic [YEAR_W-1:0]   MAX_YEAR    = 14'd9999;
  localparam logic [MONTH_W-1:0]  JAN         = 4'd1;
  localparam logic [MONTH_W-1:0]  FEB         = 4'd2;
  localparam logic [MONTH_W-1:0]  DEC         = 4'd12;
  localparam logic [DAY_W-1:0]    FIRST_DAY   = 5'd1;
  localparam logic [DAY_W-1:0]    LAST_DEC    = 5'd31;
  localparam logic [YY_W-1:0]     LAST_YY     = 7'd99;
  localparam logic [DIV100_W-1:0] DIV100_MUL  = 13'd5243;

  typedef struct packed {
    logic load;
    logic split;
    logic rem;
    logic clamp;
    logic step;
    logic emit;
  } cda_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_busy;
  } cda_status_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      FEB:                       len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: sv/cda_datapath.sv
// Date adder datapath: year split, day clamp, month walk and result register.
module cda_datapath #(
  parameter int CNT_W = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cda_pkg::cda_cmd_t               cmd,
  output cda_pkg::cda_status_t            status,
  input  logic [cda_pkg::YEAR_W-1:0]      in_year,
  input  logic [cda_pkg::MONTH_W-1:0]     in_month,
  input  logic [cda_pkg::DAY_W-1:0]       in_day,
  input  logic [cda_pkg::COUNT_W-1:0]     in_count,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [cda_pkg::YEAR_W-1:0]      out_year,
  output logic [cda_pkg::MONTH_W-1:0]     out_month,
  output logic [cda_pkg::DAY_W-1:0]       out_day,
  output logic                            out_ovf
);

  logic [cda_pkg::YEAR_W-1:0]   year;
  logic [cda_pkg::MONTH_W-1:0]  month;
  logic [cda_pkg::DAY_W-1:0]    day;
  logic [CNT_W-1:0]             left;
  logic [cda_pkg::CENT_W-1:0]   cent;
  logic [cda_pkg::YY_W-1:0]     yy;
  logic                         ovf;

  logic [cda_pkg::PROD_W-1:0]   prod;
  logic [cda_pkg::YEAR_W-1:0]   cent100;
  logic [cda_pkg::YEAR_W-1:0]   yy_full;
  logic                         leap;
  logic [cda_pkg::DAY_W-1:0]    dim;
  logic [cda_pkg::DAY_W-1:0]    room;
  logic [CNT_W-1:0]             room_ext;
  logic [cda_pkg::MONTH_W-1:0]  month_in_clamped;

  function automatic logic [cda_pkg::PROD_W-1:0] in_year_mul(
      input logic [cda_pkg::YEAR_W-1:0] y);
    return cda_pkg::PROD_W'(y) * cda_pkg::PROD_W'(cda_pkg::DIV100_MUL);
  endfunction

  assign prod    = cda_pkg::PROD_W'(in_year_mul(year));
  assign cent100 = cda_pkg::YEAR_W'({cent, 6'b0}) + cda_pkg::YEAR_W'({cent, 5'b0})
                 + cda_pkg::YEAR_W'({cent, 2'b0});
  assign yy_full = year - cent100;
  assign leap    = (year[1:0] == 2'b00) && ((yy != '0) || (cent[1:0] == 2'b00));
  assign dim     = cda_pkg::month_len(month, leap);
  assign room    = dim - day;
  assign room_ext = CNT_W'(room);

  assign status.walk_done = ovf || (left == '0);
  assign status.out_busy  = out_valid && !out_ready;

  always_comb begin
    if (in_month == '0) begin
      month_in_clamped = cda_pkg::JAN;
    end else if (in_month > cda_pkg::DEC) begin
      month_in_clamped = cda_pkg::DEC;
    end else begin
      month_in_clamped = in_month;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year  <= in_year;
      month <= month_in_clamped;
      day   <= (in_day == '0) ? cda_pkg::FIRST_DAY : in_day;
      left  <= in_count[CNT_W-1:0];
      ovf   <= 1'b0;
    end
    if (cmd.split) begin
      cent <= prod[cda_pkg::DIV100_SHIFT +: cda_pkg::CENT_W];
    end
    if (cmd.rem) begin
      yy  <= yy_full[cda_pkg::YY_W-1:0];
      ovf <= year > cda_pkg::MAX_YEAR;
    end
    if (cmd.clamp) begin
      if (day > dim) begin
        day <= dim;
      end
    end
    if (cmd.step) begin
      if (left <= room_ext) begin
        day  <= day + left[cda_pkg::DAY_W-1:0];
        left <= '0;
      end else begin
        left <= left - room_ext - CNT_W'(1);
        day  <= cda_pkg::FIRST_DAY;
        if (month == cda_pkg::DEC) begin
          month <= cda_pkg::JAN;
          if (year == cda_pkg::MAX_YEAR) begin
            ovf <= 1'b1;
          end else begin
            year <= year + cda_pkg::YEAR_W'(1);
            if (yy == cda_pkg::LAST_YY) begin
              yy   <= '0;
              cent <= cent + cda_pkg::CENT_W'(1);
            end else begin
              yy <= yy + cda_pkg::YY_W'(1);
            end
          end
        end else begin
          month <= month + cda_pkg::MONTH_W'(1);
        end
      end
    end
    if (cmd.emit) begin
      out_year  <= ovf ? cda_pkg::MAX_YEAR : year;
      out_month <= ovf ? cda_pkg::DEC : month;
      out_day   <= ovf ? cda_pkg::LAST_DEC : day;
      out_ovf   <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("result register not marked valid after emit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && !out_ready))
    else $error("pending result overwritten");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ovf) |-> (out_year == cda_pkg::MAX_YEAR &&
                                out_month == cda_pkg::DEC &&
                                out_day == cda_pkg::LAST_DEC))
    else $error("overflow result not saturated");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_month >= cda_pkg::JAN && out_month <= cda_pkg::DEC))
    else $error("result month out of range");

endmodule

FILE: sv/cda_ctrl.sv
// Date adder controller: sequences load, year split, clamp, month walk and emit.
module cda_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cda_pkg::cda_status_t  status,
  output cda_pkg::cda_cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPLIT,
    S_REM,
    S_CLAMP,
    S_WALK,
    S_EMIT
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.load  = (state == S_IDLE) && in_valid;
    cmd.split = (state == S_SPLIT);
    cmd.rem   = (state == S_REM);
    cmd.clamp = (state == S_CLAMP);
    cmd.step  = (state == S_WALK) && !status.walk_done;
    cmd.emit  = (state == S_EMIT) && !status.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_SPLIT;
        S_SPLIT: state <= S_REM;
        S_REM:   state <= S_CLAMP;
        S_CLAMP: state <= S_WALK;
        S_WALK:  if (status.walk_done) state <= S_EMIT;
        S_EMIT:  if (!status.out_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_SPLIT))
    else $error("accepted transaction did not start processing");

  a_walk_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && status.walk_done) |=> (state == S_EMIT))
    else $error("walk did not finish into emit");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("input ready while a transaction is in flight");

endmodule

FILE: sv/calendar_date_add_days.sv
// Top level of the Gregorian date adder: stream ports, controller and datapath.
// The controller runs year split, remainder, clamp, month walk and emit for each transaction;
// the walk takes one step per month crossed, plus one when the count ends inside a month.
// A new transaction is taken only after emit; emit holds while the result register is full.
// A finished result waits in the output register while the next transaction is taken.
// Reset (rst, synchronous, active high) returns the controller to idle and empties the output.
module calendar_date_add_days #(
  parameter int DAY_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // start_year[13:0], start_month[17:14], start_day[22:18],
                                 // days_to_add[38:23], zero pad[39]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // new_year[13:0], new_month[17:14], new_day[22:18],
                                 // zero pad[23]
  output logic [0:0]  m_tuser    // year_overflow[0]
);

  localparam int CNT_W = (DAY_COUNT_BITS < cda_pkg::COUNT_W) ? DAY_COUNT_BITS
                                                             : cda_pkg::COUNT_W;

  cda_pkg::cda_cmd_t    cmd;
  cda_pkg::cda_status_t status;

  logic [cda_pkg::YEAR_W-1:0]  out_year;
  logic [cda_pkg::MONTH_W-1:0] out_month;
  logic [cda_pkg::DAY_W-1:0]   out_day;
  logic                        out_ovf;

  cda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cda_datapath #(
    .CNT_W (CNT_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_year   (s_tdata[13:0]),
    .in_month  (s_tdata[17:14]),
    .in_day    (s_tdata[22:18]),
    .in_count  (s_tdata[38:23]),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_year  (out_year),
    .out_month (out_month),
    .out_day   (out_day),
    .out_ovf   (out_ovf)
  );

  assign m_tdata = {1'b0, out_day, out_month, out_year};
  assign m_tuser = out_ovf;

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the Gregorian date adder, with directed and random stimulus.
module tb_top;

  typedef struct packed {
    logic [cda_pkg::YEAR_W-1:0]  year;
    logic [cda_pkg::MONTH_W-1:0] month;
    logic [cda_pkg::DAY_W-1:0]   day;
    logic [cda_pkg::COUNT_W-1:0] count;
  } date_req_t;

  typedef struct packed {
    logic [cda_pkg::YEAR_W-1:0]  year;
    logic [cda_pkg::MONTH_W-1:0] month;
    logic [cda_pkg::DAY_W-1:0]   day;
    logic                        ovf;
  } date_result_t;

  typedef struct packed {
    date_req_t    req;
    logic         known;
    date_result_t want;
  } date_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [0:0]  m_tuser;

  logic         want_typed = 1'b0;
  date_result_t want_date = '0;
  date_result_t expected_dates [$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_left = 0;
  int items_sent = 0;
  int results_checked = 0;
  int overflow_results = 0;
  int errors = 0;

  date_row_t directed_rows [0:23] = '{
    '{'{14'd2024, 4'd2, 5'd29, 16'd0}, 1'b1, '{14'd2024, 4'd2, 5'd29, 1'b0}},
    '{'{14'd0, 4'd1, 5'd1, 16'd0}, 1'b1, '{14'd0, 4'd1, 5'd1, 1'b0}},
    '{'{14'd9999, 4'd12, 5'd31, 16'd0}, 1'b1, '{14'd9999, 4'd12, 5'd31, 1'b0}},
    '{'{14'd9999, 4'd12, 5'd31, 16'd1}, 1'b1, '{14'd9999, 4'd12, 5'd31, 1'b1}},
    '{'{14'd10000, 4'd6, 5'd15, 16'd0}, 1'b1, '{14'd9999, 4'd12, 5'd31, 1'b1}},
    '{'{14'd16383, 4'd15, 5'd31, 16'd65535}, 1'b1, '{14'd9999, 4'd12, 5'd31, 1'b1}},
    '{'{14'd2023, 4'd0, 5'd0, 16'd0}, 1'b1, '{14'd2023, 4'd1, 5'd1, 1'b0}},
    '{'{14'd2023, 4'd13, 5'd5, 16'd0}, 1'b1, '{14'd2023, 4'd12, 5'd5, 1'b0}},
    '{'{14'd2023, 4'd2, 5'd31, 16'd0}, 1'b1, '{14'd2023, 4'd2, 5'd28, 1'b0}},
    '{'{14'd2024, 4'd2, 5'd30, 16'd0}, 1'b1, '{14'd2024, 4'd2, 5'd29, 1'b0}},
    '{'{14'd1900, 4'd2, 5'd29, 16'd0}, 1'b1, '{14'd1900, 4'd2, 5'd28, 1'b0}},
    '{'{14'd2000, 4'd2, 5'd29, 16'd0}, 1'b1, '{14'd2000, 4'd2, 5'd29, 1'b0}},
    '{'{14'd2023, 4'd4, 5'd31, 16'd0}, 1'b1, '{14'd2023, 4'd4, 5'd30, 1'b0}},
    '{'{14'd2023, 4'd12, 5'd31, 16'd1}, 1'b1, '{14'd2024, 4'd1, 5'd1, 1'b0}},
    '{'{14'd2024, 4'd2, 5'd28, 16'd1}, 1'b1, '{14'd2024, 4'd2, 5'd29, 1'b0}},
    '{'{14'd2023, 4'd2, 5'd28, 16'd1}, 1'b1, '{14'd2023, 4'd3, 5'd1, 1'b0}},
    '{'{14'd2100, 4'd2, 5'd28, 16'd1}, 1'b1, '{14'd2100, 4'd3, 5'd1, 1'b0}},
    '{'{14'd9999, 4'd12, 5'd1, 16'd30}, 1'b1, '{14'd9999, 4'd12, 5'd31, 1'b0}},
    '{'{14'd9999, 4'd12, 5'd1, 16'd31}, 1'b1, '{14'd9999, 4'd12, 5'd31, 1'b1}},
    '{'{14'd0, 4'd1, 5'd1, 16'd65535}, 1'b0, '0},
    '{'{14'd2000, 4'd1, 5'd1, 16'd65535}, 1'b0, '0},
    '{'{14'd9820, 4'd1, 5'd1, 16'd65535}, 1'b0, '0},
    '{'{14'd1234, 4'd7, 5'd15, 16'd365}, 1'b0, '0},
    '{'{14'd400, 4'd2, 5'd29, 16'd366}, 1'b0, '0}
  };

  calendar_date_add_days dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    if (m == cda_pkg::FEB) return leap ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic date_result_t advance_date(date_req_t r);
    int unsigned  year, month, day, left, room;
    logic         ovf;
    date_result_t res;
    year  = r.year;
    month = r.month;
    day   = r.day;
    left  = r.count;
    if (month < cda_pkg::JAN) month = cda_pkg::JAN;
    if (month > cda_pkg::DEC) month = cda_pkg::DEC;
    if (day < cda_pkg::FIRST_DAY) day = cda_pkg::FIRST_DAY;
    if (day > month_length(year, month)) day = month_length(year, month);
    ovf = (year > cda_pkg::MAX_YEAR);
    while (!ovf && left > 0) begin
      room = month_length(year, month) - day;
      if (left <= room) begin
        day += left;
        left = 0;
      end else begin
        left -= room + 1;
        day = cda_pkg::FIRST_DAY;
        month++;
        if (month > cda_pkg::DEC) begin
          month = cda_pkg::JAN;
          year++;
          if (year > cda_pkg::MAX_YEAR) ovf = 1'b1;
        end
      end
    end
    if (ovf) begin
      year  = cda_pkg::MAX_YEAR;
      month = cda_pkg::DEC;
      day   = cda_pkg::LAST_DEC;
    end
    res.year  = year[cda_pkg::YEAR_W-1:0];
    res.month = month[cda_pkg::MONTH_W-1:0];
    res.day   = day[cda_pkg::DAY_W-1:0];
    res.ovf   = ovf;
    return res;
  endfunction

  function automatic date_req_t pick_request(bit well_formed);
    date_req_t   r;
    int unsigned sel;
    sel = $urandom_range(99);
    if (well_formed) begin
      if (sel < 45) r.year = cda_pkg::YEAR_W'($urandom_range(9999));
      else if (sel < 70) r.year = cda_pkg::YEAR_W'(100 * $urandom_range(99, 1)
                                                    + $urandom_range(4) - 2);
      else r.year = cda_pkg::YEAR_W'($urandom_range(9999, 9790));
      r.month = cda_pkg::MONTH_W'($urandom_range(12, 1));
      r.day   = cda_pkg::DAY_W'($urandom_range(month_length(r.year, r.month), 1));
    end else begin
      r.year  = cda_pkg::YEAR_W'($urandom_range(16383));
      r.month = cda_pkg::MONTH_W'($urandom_range(15));
      r.day   = cda_pkg::DAY_W'($urandom_range(31));
    end
    sel = $urandom_range(99);
    if (sel < 78) r.count = cda_pkg::COUNT_W'($urandom_range(1500));
    else if (sel < 82) r.count = '0;
    else if (sel < 94) r.count = cda_pkg::COUNT_W'($urandom);
    else r.count = cda_pkg::COUNT_W'($urandom_range(65535, 60000));
    return r;
  endfunction

  task automatic send_date(date_req_t r, logic known, date_result_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= {1'b0, r.count, r.day, r.month, r.year};
    want_typed <= known;
    want_date  <= want;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      if (want_typed) expected_dates.push_back(want_date);
      else expected_dates.push_back(advance_date(date_req_t'{
             s_tdata[13:0], s_tdata[17:14], s_tdata[22:18], s_tdata[38:23]}));
      items_sent++;
    end
  end

  always @(posedge clk) begin
    date_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_dates.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d ovf %0d",
                 $time, m_tdata[13:0], m_tdata[17:14], m_tdata[22:18], m_tuser[0]);
        errors++;
      end else begin
        want = expected_dates.pop_front();
        check_field("new_year", want.year, m_tdata[13:0]);
        check_field("new_month", want.month, m_tdata[17:14]);
        check_field("new_day", want.day, m_tdata[22:18]);
        check_field("year_overflow", want.ovf, m_tuser[0]);
        if (m_tuser[0]) overflow_results++;
        results_checked++;
      end
    end
  end

  initial begin
    #42000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int        idle_pct [4];
    int        stall_pct [4];
    date_req_t short_req;
    idle_pct  = '{0, 71, 0, 20};
    stall_pct = '{0, 0, 71, 20};
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_date(directed_rows[i].req, directed_rows[i].known, directed_rows[i].want);
    drain_results();

    // hold the output while short walks pile up behind it
    @(posedge clk);
    hold_left = 600;
    @(negedge clk);
    repeat (8) begin
      short_req = pick_request(1'b1);
      short_req.count = short_req.count & 16'h003F;
      send_date(short_req, 1'b0, '0);
    end
    drain_results();

    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = idle_pct[p];
      sink_stall_pct = stall_pct[p];
      repeat (60) send_date(pick_request($urandom_range(99) < 75), 1'b0, '0);
      drain_results();
    end

    sink_stall_pct = 0;
    repeat (2200) @(negedge clk);
    $display("Sent %0d dates and checked %0d results, %0d of them saturated at the year limit,",
             items_sent, results_checked, overflow_results);
    $display("under four idle/stall mixes plus a long output hold; %0d mismatches.", errors);
    if (errors == 0 && expected_dates.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: calendar_date_add_days.f
sv/cda_pkg.sv
sv/cda_datapath.sv
sv/cda_ctrl.sv
sv/calendar_date_add_days.sv
dv/tb_top.sv
